/* rtl/slc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Shared register indexes and status types for the strided slice selector.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_ROWS   = 3'd0,
        REG_IN_COLS   = 3'd1,
        REG_ROW_START = 3'd2,
        REG_ROW_STEP  = 3'd3,
        REG_ROW_END   = 3'd4,
        REG_COL_START = 3'd5,
        REG_COL_STEP  = 3'd6,
        REG_COL_END   = 3'd7
    } t_cfg_reg;

    // Per-dimension decision for the element now being looked at.
    typedef struct packed {
        logic ok;    // slice settings of this dimension are valid
        logic past;  // coordinate has reached the resolved start
        logic hit;   // coordinate is a selected index
        logic last;  // selected index is the final one of the dimension
    } t_dim_stat;

endpackage

/* rtl/slc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_in_if
// Element stream channel: valid/ready handshake with one tensor element.
// ----------------------------------------------------------------------------
interface slc_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

/* rtl/slc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_out_if
// Result stream channel: valid/ready handshake with a selected element.
// ----------------------------------------------------------------------------
interface slc_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] picked_value;
    logic                  last_of_slice;
    logic                  bad_config;

    modport source (output valid, output picked_value, output last_of_slice,
                    output bad_config, input ready);
    modport sink   (input valid, input picked_value, input last_of_slice,
                    input bad_config, output ready);
endinterface

/* rtl/slc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_cfg
// Configuration register file: sizes and slice triples of both dimensions.
// ----------------------------------------------------------------------------
module slc_cfg
    import slc_pkg::*;
#(
    parameter int DIM_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [DIM_WIDTH:0]          i_cfg_data,
    output logic [DIM_WIDTH-1:0]        o_in_rows,
    output logic [DIM_WIDTH-1:0]        o_in_cols,
    output logic signed [DIM_WIDTH:0]   o_row_start,
    output logic [DIM_WIDTH-1:0]        o_row_step,
    output logic signed [DIM_WIDTH:0]   o_row_end,
    output logic signed [DIM_WIDTH:0]   o_col_start,
    output logic [DIM_WIDTH-1:0]        o_col_step,
    output logic signed [DIM_WIDTH:0]   o_col_end
);

    logic [DIM_WIDTH-1:0]      r_in_rows, r_in_cols, r_row_step, r_col_step;
    logic signed [DIM_WIDTH:0] r_row_start, r_row_end, r_col_start, r_col_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rows   <= DIM_WIDTH'(1);
            r_in_cols   <= DIM_WIDTH'(1);
            r_row_start <= '0;
            r_row_step  <= '0;
            r_row_end   <= '0;
            r_col_start <= '0;
            r_col_step  <= '0;
            r_col_end   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IN_ROWS:   r_in_rows   <= i_cfg_data[DIM_WIDTH-1:0];
                REG_IN_COLS:   r_in_cols   <= i_cfg_data[DIM_WIDTH-1:0];
                REG_ROW_START: r_row_start <= i_cfg_data;
                REG_ROW_STEP:  r_row_step  <= i_cfg_data[DIM_WIDTH-1:0];
                REG_ROW_END:   r_row_end   <= i_cfg_data;
                REG_COL_START: r_col_start <= i_cfg_data;
                REG_COL_STEP:  r_col_step  <= i_cfg_data[DIM_WIDTH-1:0];
                REG_COL_END:   r_col_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_rows   = r_in_rows;
    assign o_in_cols   = r_in_cols;
    assign o_row_start = r_row_start;
    assign o_row_step  = r_row_step;
    assign o_row_end   = r_row_end;
    assign o_col_start = r_col_start;
    assign o_col_step  = r_col_step;
    assign o_col_end   = r_col_end;

endmodule

/* rtl/slc_dim.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_dim
// One dimension of the slice: resolves the triple, decides whether the
// current coordinate is selected and computes the next phase and pick count.
// ----------------------------------------------------------------------------
module slc_dim
    import slc_pkg::*;
#(
    parameter int DIM_WIDTH = 16
) (
    input  logic [DIM_WIDTH-1:0]      i_size,
    input  logic signed [DIM_WIDTH:0] i_start,
    input  logic [DIM_WIDTH-1:0]      i_step,
    input  logic signed [DIM_WIDTH:0] i_end,
    input  logic [DIM_WIDTH-1:0]      i_pos,
    input  logic [DIM_WIDTH-1:0]      i_phase,
    input  logic [DIM_WIDTH-1:0]      i_pick,
    output t_dim_stat                 o_stat,
    output logic [DIM_WIDTH-1:0]      o_phase_nx,
    output logic [DIM_WIDTH-1:0]      o_pick_nx
);

    localparam int SW = DIM_WIDTH + 2;       // signed working width of bounds
    localparam int PW = 2 * DIM_WIDTH + 1;   // product plus two steps

    logic                   w_all_zero;
    logic signed [SW-1:0]   w_size, w_s, w_e, w_s_adj, w_e_adj, w_span_full, w_pos;
    logic [DIM_WIDTH-1:0]   w_step_eff;
    logic [DIM_WIDTH-1:0]   w_span;
    logic [2*DIM_WIDTH-1:0] w_prod;
    logic [PW-1:0]          w_next_end, w_after_end;
    logic [DIM_WIDTH:0]     w_phase_inc;
    logic                   w_ok, w_past, w_in_range, w_hit;

    assign w_all_zero = (i_start == '0) && (i_step == '0) && (i_end == '0);
    assign w_size     = signed'({2'b00, i_size});
    assign w_pos      = signed'({2'b00, i_pos});
    assign w_s        = signed'({i_start[DIM_WIDTH], i_start});
    assign w_e        = w_all_zero ? w_size : signed'({i_end[DIM_WIDTH], i_end});

    // Negative bounds count back from the dimension size.
    assign w_s_adj = w_s[SW-1] ? (w_s + w_size) : w_s;
    assign w_e_adj = w_e[SW-1] ? (w_e + w_size) : w_e;

    // The all-zero triple and an invalid zero step both run with stride one.
    assign w_step_eff = (i_step == '0) ? DIM_WIDTH'(1) : i_step;

    assign w_ok = (i_size != '0) && ((i_step != '0) || w_all_zero) && !w_s_adj[SW-1]
                  && (w_s_adj <= w_e_adj) && (w_e_adj <= w_size);

    // Under valid settings the span lies in 0 .. size.
    assign w_span_full = w_e_adj - w_s_adj;
    assign w_span      = w_span_full[DIM_WIDTH-1:0];

    // pick < floor(span/step) holds exactly when (pick+1)*step <= span.
    assign w_prod      = i_pick * w_step_eff;
    assign w_next_end  = PW'(w_prod) + PW'(w_step_eff);
    assign w_after_end = w_next_end + PW'(w_step_eff);
    assign w_in_range  = w_next_end <= PW'(w_span);

    assign w_past = w_pos >= w_s_adj;
    assign w_hit  = w_ok && w_past && (i_phase == '0) && w_in_range;

    assign w_phase_inc = {1'b0, i_phase} + (DIM_WIDTH+1)'(1);

    always_comb begin
        o_phase_nx = i_phase;
        if (w_past) begin
            o_phase_nx = (w_phase_inc >= {1'b0, w_step_eff}) ? '0
                                                             : w_phase_inc[DIM_WIDTH-1:0];
        end
    end

    assign o_pick_nx = w_hit ? (i_pick + DIM_WIDTH'(1)) : i_pick;

    assign o_stat.ok   = w_ok;
    assign o_stat.past = w_past;
    assign o_stat.hit  = w_hit;
    assign o_stat.last = w_after_end > PW'(w_span);

endmodule

/* rtl/strided_slice_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_slice_select
// Streams a row-major rank-2 tensor and forwards the elements of a strided
// slice, marking the final selected element.
// ----------------------------------------------------------------------------
// The block takes one element per clock and keeps that rate indefinitely
// while the result side accepts; an element is first held in the input
// register and then moves to the result register once the result slot is
// free. The clock period is set by the per-dimension check that multiplies
// the pick count by the step and compares the result against the slice
// span. Write the slice settings only while no element is in flight; the
// coordinate counters run on across setting changes and wrap to the origin
// after the last element of a tensor.
// With invalid settings every element yields a result with bad_config set.
// ----------------------------------------------------------------------------
module strided_slice_select
    import slc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int DIM_WIDTH  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_WIDTH:0]   i_cfg_data,
    slc_in_if.sink               i_elem,
    slc_out_if.source            o_pick
);

    logic [DIM_WIDTH-1:0]      w_in_rows, w_in_cols, w_row_step, w_col_step;
    logic signed [DIM_WIDTH:0] w_row_start, w_row_end, w_col_start, w_col_end;

    logic [DIM_WIDTH-1:0]  r_row_pos, r_col_pos, r_row_phase, r_col_phase;
    logic [DIM_WIDTH-1:0]  r_row_pick, r_col_pick;
    logic [DIM_WIDTH-1:0]  n_row_pos, n_col_pos, n_row_phase, n_col_phase;
    logic [DIM_WIDTH-1:0]  n_row_pick, n_col_pick;
    logic [DIM_WIDTH-1:0]  w_row_phase_nx, w_col_phase_nx, w_row_pick_nx, w_col_pick_nx;
    logic [DIM_WIDTH:0]    w_row_pos_inc, w_col_pos_inc;

    logic                  r_in_valid;
    logic [DATA_WIDTH-1:0] r_in_data;
    logic                  r_out_valid, r_out_last, r_out_bad;
    logic [DATA_WIDTH-1:0] r_out_data;

    t_dim_stat w_row_stat, w_col_stat;
    logic      w_good, w_produce, w_out_free, w_adv, w_in_xfer;

    slc_cfg #(.DIM_WIDTH(DIM_WIDTH)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_in_rows   (w_in_rows),
        .o_in_cols   (w_in_cols),
        .o_row_start (w_row_start),
        .o_row_step  (w_row_step),
        .o_row_end   (w_row_end),
        .o_col_start (w_col_start),
        .o_col_step  (w_col_step),
        .o_col_end   (w_col_end)
    );

    slc_dim #(.DIM_WIDTH(DIM_WIDTH)) u_row (
        .i_size     (w_in_rows),
        .i_start    (w_row_start),
        .i_step     (w_row_step),
        .i_end      (w_row_end),
        .i_pos      (r_row_pos),
        .i_phase    (r_row_phase),
        .i_pick     (r_row_pick),
        .o_stat     (w_row_stat),
        .o_phase_nx (w_row_phase_nx),
        .o_pick_nx  (w_row_pick_nx)
    );

    slc_dim #(.DIM_WIDTH(DIM_WIDTH)) u_col (
        .i_size     (w_in_cols),
        .i_start    (w_col_start),
        .i_step     (w_col_step),
        .i_end      (w_col_end),
        .i_pos      (r_col_pos),
        .i_phase    (r_col_phase),
        .i_pick     (r_col_pick),
        .o_stat     (w_col_stat),
        .o_phase_nx (w_col_phase_nx),
        .o_pick_nx  (w_col_pick_nx)
    );

    // Handshake: the held element moves on whenever the result slot is free.
    assign w_out_free   = !r_out_valid || o_pick.ready;
    assign w_adv        = r_in_valid && w_out_free;
    assign i_elem.ready = !r_in_valid || w_adv;
    assign w_in_xfer    = i_elem.valid && i_elem.ready;

    assign w_good    = w_row_stat.ok && w_col_stat.ok;
    assign w_produce = !w_good || (w_row_stat.hit && w_col_stat.hit);

    assign w_row_pos_inc = {1'b0, r_row_pos} + (DIM_WIDTH+1)'(1);
    assign w_col_pos_inc = {1'b0, r_col_pos} + (DIM_WIDTH+1)'(1);

    // Column counters step every element; row counters step at end of a row.
    always_comb begin
        n_row_pos   = r_row_pos;
        n_row_phase = r_row_phase;
        n_row_pick  = r_row_pick;
        n_col_pos   = w_col_pos_inc[DIM_WIDTH-1:0];
        n_col_phase = w_col_phase_nx;
        n_col_pick  = w_col_pick_nx;
        if (w_col_pos_inc >= {1'b0, w_in_cols}) begin
            n_col_pos   = '0;
            n_col_phase = '0;
            n_col_pick  = '0;
            if (w_row_pos_inc >= {1'b0, w_in_rows}) begin
                n_row_pos   = '0;
                n_row_phase = '0;
                n_row_pick  = '0;
            end else begin
                n_row_pos   = w_row_pos_inc[DIM_WIDTH-1:0];
                n_row_phase = w_row_phase_nx;
                n_row_pick  = w_row_pick_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_row_phase <= '0;
            r_col_phase <= '0;
            r_row_pick  <= '0;
            r_col_pick  <= '0;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= w_produce;
                r_row_pos   <= n_row_pos;
                r_col_pos   <= n_col_pos;
                r_row_phase <= n_row_phase;
                r_col_phase <= n_col_phase;
                r_row_pick  <= n_row_pick;
                r_col_pick  <= n_col_pick;
            end else if (o_pick.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_data <= i_elem.element_value;
        end
        if (w_adv) begin
            r_out_data <= w_good ? r_in_data : '0;
            r_out_last <= w_good && w_row_stat.last && w_col_stat.last;
            r_out_bad  <= !w_good;
        end
    end

    assign o_pick.valid         = r_out_valid;
    assign o_pick.picked_value  = r_out_data;
    assign o_pick.last_of_slice = r_out_last;
    assign o_pick.bad_config    = r_out_bad;

    // A flagged result never carries data or an end-of-slice mark.
    a_bad_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_data == '0 && !r_out_last))
        else $error("bad_config result carries data or last mark");

    // A held element is not dropped while the result slot is blocked.
    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_pick.ready) |=> r_in_valid)
        else $error("held element lost while output stalled");

    // A transfer out of the result slot with nothing behind it empties the slot.
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_pick.ready && !r_in_valid) |=> !r_out_valid)
        else $error("result repeated after its transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule
